### hw/rtl/fet_pkg.sv
// Shared constants and types for the escape-time fractal point evaluator.
package fet_pkg;

    // Multiplier limb width: the shared unit is one LIMB_W x LIMB_W multiplier
    localparam int LIMB_W = 32;

    // Fixed field widths
    localparam int ITER_W     = 16;
    localparam int RADIUS_W   = 31;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Color mapping shifts (4n and 8n)
    localparam int RED_SHIFT   = 2;
    localparam int GREEN_SHIFT = 3;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_MAX_ITER = 2'd0;
    localparam cfg_idx_t CFG_RADIUS   = 2'd1;

    // Configuration reset values
    localparam logic [ITER_W-1:0]   MAX_ITER_RESET = 16'd1000;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET   = 31'd1073741824;

    // Which product the shared multiplier is forming
    typedef logic [1:0] op_t;
    localparam op_t OP_XX = 2'd0;
    localparam op_t OP_YY = 2'd1;
    localparam op_t OP_XY = 2'd2;

endpackage

### hw/rtl/fractal_escape_time.sv
// Escape-time fractal point evaluator (Mandelbrot / Burning Ship), top level.
//
//  channel | direction | signals                                   | transfers
//  --------+-----------+-------------------------------------------+----------------------
//  s_      | in        | s_valid s_ready s_mode s_c_real s_c_imag  | one point
//  m_      | out       | m_valid m_ready m_iter_count m_escaped    | one result per point
//          |           | m_red m_green m_blue                      |
//  cfg_    | in        | cfg_valid cfg_ready cfg_index cfg_data    | one register write
//
//  Every product goes through one shared LIMB_W x LIMB_W multiplier, NL*NL partial
//  products per product, NL = ceil(COORD_WIDTH / LIMB_W). A product is loaded, then built
//  one limb pair at a time, then scaled and saturated. One iteration forms x*x and y*y,
//  runs the bound test, forms x*y and ends with two add steps.
//  s_ready is high only while idle; a finished result waits in the output register
//  and the next point is taken while it is stalled. Reset is synchronous, active low.
module fractal_escape_time #(
    parameter int FRAC_BITS   = 28,
    parameter int COORD_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // point input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic signed [COORD_WIDTH-1:0]     s_c_real,
    input  logic signed [COORD_WIDTH-1:0]     s_c_imag,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fet_pkg::ITER_W-1:0]        m_iter_count,
    output logic                              m_escaped,
    output logic [fet_pkg::COLOR_W-1:0]       m_red,
    output logic [fet_pkg::COLOR_W-1:0]       m_green,
    output logic [fet_pkg::COLOR_W-1:0]       m_blue,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  fet_pkg::cfg_idx_t                 cfg_index,
    input  logic [fet_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW        = COORD_WIDTH;
    localparam int LW        = fet_pkg::LIMB_W;
    localparam int NL        = (CW + LW - 1) / LW;
    localparam int MW        = NL * LW;
    localparam int AW        = 2 * MW;
    localparam int MUL_STEPS = NL * NL;
    localparam int CNT_W     = $clog2(MUL_STEPS + 1);
    localparam int CMPW      = (CW > fet_pkg::RADIUS_W) ? CW : fet_pkg::RADIUS_W;

    localparam logic [CW-1:0] FX_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] FX_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE    = {{(CW-1){1'b0}}, 1'b1};

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TEST  = 4'd1;
    localparam logic [3:0] S_MLOAD = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_MFIN  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_UPD1  = 4'd6;
    localparam logic [3:0] S_UPD2  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // saturating add or subtract on CW-bit two's complement
    function automatic logic [CW-1:0] sat_addsub(input logic [CW-1:0] a,
                                                 input logic [CW-1:0] b,
                                                 input logic sub);
        logic [CW:0] ea;
        logic [CW:0] eb;
        logic [CW:0] s;
        ea = {a[CW-1], a};
        eb = {b[CW-1], b};
        s  = sub ? (ea - eb) : (ea + eb);
        if (s[CW] != s[CW-1]) begin
            return s[CW] ? FX_MIN : FX_MAX;
        end
        return s[CW-1:0];
    endfunction

    // magnitude, zero-extended to the limb grid
    function automatic logic [MW-1:0] magnitude(input logic [CW-1:0] a);
        logic [CW-1:0] t;
        t = a[CW-1] ? (~a + ONE) : a;
        return MW'(t);
    endfunction

    // absolute value, most negative maps to largest positive
    function automatic logic [CW-1:0] fx_abs(input logic [CW-1:0] a);
        if (a == FX_MIN) begin
            return FX_MAX;
        end
        return a[CW-1] ? (~a + ONE) : a;
    endfunction

    // control
    logic [3:0]                    state_reg, state_next;
    logic                          m_valid_reg, m_valid_next;
    logic [fet_pkg::ITER_W-1:0]    max_iter_reg, max_iter_next;
    logic [fet_pkg::RADIUS_W-1:0]  radius_reg, radius_next;
    // datapath
    logic                          ship_reg, ship_next;
    logic [CW-1:0]                 cr_reg, cr_next;
    logic [CW-1:0]                 ci_reg, ci_next;
    logic [CW-1:0]                 x_reg, x_next;
    logic [CW-1:0]                 y_reg, y_next;
    logic [CW-1:0]                 xx_reg, xx_next;
    logic [CW-1:0]                 yy_reg, yy_next;
    logic [CW-1:0]                 xy_reg, xy_next;
    logic [fet_pkg::ITER_W-1:0]    n_reg, n_next;
    logic                          esc_reg, esc_next;
    fet_pkg::op_t                  op_reg, op_next;
    // shared multiplier
    logic [MW-1:0]                 a_mag_reg, a_mag_next;
    logic [MW-1:0]                 b_mag_reg, b_mag_next;
    logic                          neg_reg, neg_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [2*LW-1:0]               pp_reg, pp_next;
    logic [CNT_W-1:0]              pos_reg, pos_next;
    logic [AW-1:0]                 acc_reg, acc_next;
    // output register
    logic [fet_pkg::ITER_W-1:0]    out_cnt_reg, out_cnt_next;
    logic                          out_esc_reg, out_esc_next;
    logic [fet_pkg::COLOR_W-1:0]   out_red_reg, out_red_next;
    logic [fet_pkg::COLOR_W-1:0]   out_green_reg, out_green_next;

    // combinational helpers
    logic [LW-1:0]                 a_limb;
    logic [LW-1:0]                 b_limb;
    logic [AW-1:0]                 quot;
    logic                          prod_big;
    logic [CW-1:0]                 prod_mag;
    logic [CW-1:0]                 prod_res;
    logic [CW-1:0]                 m2;
    logic                          escape_hit;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // limb pick for the current partial product
    assign a_limb = LW'(a_mag_reg >> (LW * (cnt_reg / NL)));
    assign b_limb = LW'(b_mag_reg >> (LW * (cnt_reg % NL)));

    // scale, sign and saturate the finished product
    assign quot     = acc_reg >> FRAC_BITS;
    assign prod_big = |quot[AW-1:CW-1];
    assign prod_mag = quot[CW-1:0];
    always_comb begin
        if (prod_big) begin
            prod_res = neg_reg ? FX_MIN : FX_MAX;
        end else begin
            prod_res = neg_reg ? (~prod_mag + ONE) : prod_mag;
        end
    end

    // bound test on |z|^2
    assign m2         = sat_addsub(xx_reg, yy_reg, 1'b0);
    assign escape_hit = CMPW'(m2) > CMPW'(radius_reg);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg;
        max_iter_next  = max_iter_reg;
        radius_next    = radius_reg;
        ship_next      = ship_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        xx_next        = xx_reg;
        yy_next        = yy_reg;
        xy_next        = xy_reg;
        n_next         = n_reg;
        esc_next       = esc_reg;
        op_next        = op_reg;
        a_mag_next     = a_mag_reg;
        b_mag_next     = b_mag_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        pp_next        = pp_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        out_cnt_next   = out_cnt_reg;
        out_esc_next   = out_esc_reg;
        out_red_next   = out_red_reg;
        out_green_next = out_green_reg;

        // configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                fet_pkg::CFG_MAX_ITER: max_iter_next = cfg_data[fet_pkg::ITER_W-1:0];
                fet_pkg::CFG_RADIUS:   radius_next   = cfg_data[fet_pkg::RADIUS_W-1:0];
                default: ;
            endcase
        end

        // result drains
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ship_next  = s_mode;
                    cr_next    = s_c_real;
                    ci_next    = s_c_imag;
                    x_next     = s_c_real;
                    y_next     = s_c_imag;
                    n_next     = '0;
                    state_next = S_TEST;
                end
            end
            S_TEST: begin
                if (n_reg < max_iter_reg) begin
                    op_next    = fet_pkg::OP_XX;
                    state_next = S_MLOAD;
                end else begin
                    esc_next   = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_MLOAD: begin
                a_mag_next = magnitude(x_reg);
                b_mag_next = (op_reg == fet_pkg::OP_XX) ? magnitude(x_reg) : magnitude(y_reg);
                if (op_reg == fet_pkg::OP_YY) begin
                    a_mag_next = magnitude(y_reg);
                end
                neg_next   = (op_reg == fet_pkg::OP_XY) ? (x_reg[CW-1] ^ y_reg[CW-1]) : 1'b0;
                cnt_next   = '0;
                acc_next   = '0;
                state_next = S_MUL;
            end
            S_MUL: begin
                // multiply one limb pair, accumulate the previous one
                if (cnt_reg < CNT_W'(MUL_STEPS)) begin
                    pp_next  = (2*LW)'(a_limb) * (2*LW)'(b_limb);
                    pos_next = CNT_W'(cnt_reg / NL + cnt_reg % NL);
                end
                if (cnt_reg != '0) begin
                    acc_next = acc_reg + (AW'(pp_reg) << (LW * pos_reg));
                end
                if (cnt_reg == CNT_W'(MUL_STEPS)) begin
                    state_next = S_MFIN;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_MFIN: begin
                case (op_reg)
                    fet_pkg::OP_XX: begin
                        xx_next    = prod_res;
                        op_next    = fet_pkg::OP_YY;
                        state_next = S_MLOAD;
                    end
                    fet_pkg::OP_YY: begin
                        yy_next    = prod_res;
                        state_next = S_CHK;
                    end
                    default: begin
                        xy_next    = prod_res;
                        state_next = S_UPD1;
                    end
                endcase
            end
            S_CHK: begin
                if (escape_hit) begin
                    esc_next   = 1'b1;
                    state_next = S_OUT;
                end else begin
                    if (ship_reg) begin
                        x_next = fx_abs(x_reg);
                        y_next = fx_abs(y_reg);
                    end
                    op_next    = fet_pkg::OP_XY;
                    state_next = S_MLOAD;
                end
            end
            S_UPD1: begin
                x_next     = sat_addsub(xx_reg, yy_reg, 1'b1);
                y_next     = sat_addsub(xy_reg, xy_reg, 1'b0);
                state_next = S_UPD2;
            end
            S_UPD2: begin
                x_next     = sat_addsub(x_reg, cr_reg, 1'b0);
                y_next     = sat_addsub(y_reg, ci_reg, 1'b0);
                n_next     = n_reg + fet_pkg::ITER_W'(1);
                state_next = S_TEST;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_cnt_next   = n_reg;
                    out_esc_next   = esc_reg;
                    out_red_next   = esc_reg ?
                        fet_pkg::COLOR_W'(n_reg << fet_pkg::RED_SHIFT) : '0;
                    out_green_next = esc_reg ?
                        fet_pkg::COLOR_W'(n_reg << fet_pkg::GREEN_SHIFT) : '0;
                    m_valid_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            max_iter_reg <= fet_pkg::MAX_ITER_RESET;
            radius_reg   <= fet_pkg::RADIUS_RESET;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            max_iter_reg <= max_iter_next;
            radius_reg   <= radius_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        ship_reg      <= ship_next;
        cr_reg        <= cr_next;
        ci_reg        <= ci_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        xx_reg        <= xx_next;
        yy_reg        <= yy_next;
        xy_reg        <= xy_next;
        n_reg         <= n_next;
        esc_reg       <= esc_next;
        op_reg        <= op_next;
        a_mag_reg     <= a_mag_next;
        b_mag_reg     <= b_mag_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        pp_reg        <= pp_next;
        pos_reg       <= pos_next;
        acc_reg       <= acc_next;
        out_cnt_reg   <= out_cnt_next;
        out_esc_reg   <= out_esc_next;
        out_red_reg   <= out_red_next;
        out_green_reg <= out_green_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_iter_count = out_cnt_reg;
    assign m_escaped    = out_esc_reg;
    assign m_red        = out_red_reg;
    assign m_green      = out_green_reg;
    assign m_blue       = out_red_reg;

endmodule

### hw/rtl/fet_checker.sv
// Port-level assertions for the fractal evaluator, bound to the top level.
module fet_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [fet_pkg::ITER_W-1:0]      m_iter_count,
    input logic                            m_escaped,
    input logic [fet_pkg::COLOR_W-1:0]     m_red,
    input logic [fet_pkg::COLOR_W-1:0]     m_green,
    input logic [fet_pkg::COLOR_W-1:0]     m_blue
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_iter_count) && $stable(m_escaped))
        else $error("stalled result changed");

    // one point at a time: busy right after a point is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("point accepted while busy");

    // points inside the set are black
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_escaped |-> m_red == '0 && m_green == '0 && m_blue == '0)
        else $error("inside point not black");

    // escaped color follows the count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_escaped |->
            m_red == fet_pkg::COLOR_W'(m_iter_count << fet_pkg::RED_SHIFT) &&
            m_green == fet_pkg::COLOR_W'(m_iter_count << fet_pkg::GREEN_SHIFT) &&
            m_blue == m_red)
        else $error("color does not match count");

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind fractal_escape_time fet_checker u_fet_checker (.*);
